// ===== src/sfpc_pkg.sv =====
// Shared types and constants for the sensor frame parser and converter.
// No dependencies; every other file in src refers to this package by scoped names.
package sfpc_pkg;

	// Default number of captured frames held between the parser and the converter.
	localparam int QUEUE_DEPTH = 2;

	// Raw words of one complete frame, as captured by the parser.
	typedef struct packed {
		logic [15:0] node;
		logic [15:0] battery;
		logic [15:0] temp;
		logic [15:0] humidity;
		logic [15:0] light;
		logic [15:0] infrared;
	} frame_t;

endpackage

// ===== src/sfpc_front.sv =====
// Byte-level frame parser: hunts for the start flag and type byte, then captures raw words.
// Depends on sfpc_pkg for the frame record pushed into the queue.
module sfpc_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [7:0]      byte_in,
	input  logic            q_full,
	output logic            push,
	output sfpc_pkg::frame_t push_data
);

	typedef enum logic [1:0] {
		PH_HUNT  = 2'd0,
		PH_FLAG  = 2'd1,
		PH_FRAME = 2'd2
	} phase_t;

	localparam logic [7:0] FLAG_BYTE = 8'h7E;
	localparam logic [7:0] TYPE_BYTE = 8'h45;

	localparam logic [4:0] OFS_NODE_HI  = 5'd4;
	localparam logic [4:0] OFS_NODE_LO  = 5'd5;
	localparam logic [4:0] OFS_BAT_HI   = 5'd9;
	localparam logic [4:0] OFS_BAT_LO   = 5'd10;
	localparam logic [4:0] OFS_TEMP_HI  = 5'd11;
	localparam logic [4:0] OFS_TEMP_LO  = 5'd12;
	localparam logic [4:0] OFS_HUM_HI   = 5'd13;
	localparam logic [4:0] OFS_HUM_LO   = 5'd14;
	localparam logic [4:0] OFS_LIGHT_HI = 5'd15;
	localparam logic [4:0] OFS_LIGHT_LO = 5'd16;
	localparam logic [4:0] OFS_IR_HI    = 5'd17;
	localparam logic [4:0] OFS_LAST     = 5'd18;

	phase_t      phase_q;
	logic [4:0]  offset_q;
	logic [4:0]  offset_nx;
	logic [7:0]  hold_q;
	logic [15:0] node_q;
	logic [15:0] bat_q;
	logic [15:0] temp_q;
	logic [15:0] hum_q;
	logic [15:0] light_q;
	logic [15:0] word;
	logic        take;

	assign in_stall  = q_full;
	assign take      = in_valid && !in_stall;
	assign offset_nx = offset_q + 5'd1;
	assign word      = {hold_q, byte_in};
	assign push      = take && (phase_q == PH_FRAME) && (offset_nx == OFS_LAST);

	assign push_data.node     = node_q;
	assign push_data.battery  = bat_q;
	assign push_data.temp     = temp_q;
	assign push_data.humidity = hum_q;
	assign push_data.light    = light_q;
	assign push_data.infrared = word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			offset_q <= '0;
		end else if (take) begin
			unique case (phase_q)
				PH_FLAG: begin
					// A repeated flag keeps the match armed.
					if (byte_in == TYPE_BYTE) begin
						phase_q  <= PH_FRAME;
						offset_q <= '0;
					end else if (byte_in != FLAG_BYTE) begin
						phase_q <= PH_HUNT;
					end
				end
				PH_FRAME: begin
					if (offset_nx >= OFS_LAST) begin
						phase_q  <= PH_HUNT;
						offset_q <= '0;
					end else begin
						offset_q <= offset_nx;
					end
				end
				default: begin
					phase_q <= (byte_in == FLAG_BYTE) ? PH_FLAG : PH_HUNT;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take && (phase_q == PH_FRAME)) begin
			unique case (offset_nx)
				OFS_NODE_HI, OFS_BAT_HI, OFS_TEMP_HI, OFS_HUM_HI, OFS_LIGHT_HI,
				OFS_IR_HI: begin
					hold_q <= byte_in;
				end
				OFS_NODE_LO:  node_q  <= word;
				OFS_BAT_LO:   bat_q   <= word;
				OFS_TEMP_LO:  temp_q  <= word;
				OFS_HUM_LO:   hum_q   <= word;
				OFS_LIGHT_LO: light_q <= word;
				default: begin
				end
			endcase
		end
	end

`ifndef SYNTH
	// The frame always ends on its last byte, so the count never runs past it.
	a_offset_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_FRAME) |-> (offset_q < OFS_LAST))
		else $error("frame byte count ran past the last byte");
`endif

endmodule

// ===== src/sfpc_queue.sv =====
// Small register FIFO that carries captured frames from the parser to the converter.
// Depends on sfpc_pkg for the frame record type.
module sfpc_queue #(
	parameter int DEPTH = sfpc_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sfpc_pkg::frame_t push_data,
	output logic             full,
	input  logic             pop,
	output sfpc_pkg::frame_t pop_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	sfpc_pkg::frame_t entry_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = entry_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_data;
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("frame queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("frame queue read while empty");
`endif

endmodule

// ===== src/sfpc_back.sv =====
// Sequenced converter: turns one captured frame into scaled readings, one multiply a step,
// with a reciprocal multiply for the humidity divide. Depends on sfpc_pkg for the frame record.
module sfpc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  sfpc_pkg::frame_t    q_data,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [15:0]         node_id,
	output logic [15:0]         battery_mv,
	output logic signed [16:0]  temp_centideg,
	output logic signed [19:0]  humidity_centipct,
	output logic [23:0]         light_centilux,
	output logic [20:0]         infrared_centilux
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BAT,
		ST_LIGHT,
		ST_IR,
		ST_A,
		ST_M2,
		ST_Q1,
		ST_M8K,
		ST_SUM,
		ST_CHK,
		ST_EST,
		ST_PROD,
		ST_FIX,
		ST_HUM,
		ST_OUT
	} state_t;

	// Humidity is worked in units of 1e-10 percent and offset by +500000 centipercent,
	// so the divide by 1e8 runs on a non-negative value and the clamp becomes two compares.
	localparam logic signed [47:0] HUM_BIAS  = 48'sd49979532000000;
	localparam logic signed [47:0] HUM_TOP   = 48'sd100000100000000;
	localparam logic [26:0]        DIVISOR   = 27'd100000000;
	localparam logic [23:0]        RECIP     = 24'd11258999;
	localparam logic signed [19:0] HUM_MAX   = 20'sd500000;
	localparam logic signed [19:0] HUM_MIN   = -20'sd500000;
	localparam logic signed [20:0] HUM_SHIFT = 21'sd500000;

	state_t                state_q;
	sfpc_pkg::frame_t      fr_q;
	logic [15:0]           bat_q;
	logic [23:0]           light_q;
	logic [20:0]           ir_q;
	logic signed [16:0]    temp_q;
	logic signed [31:0]    a_q;
	logic signed [34:0]    m2_q;
	logic signed [47:0]    acc_q;
	logic signed [47:0]    m8k_q;
	logic [47:0]           r_q;
	logic [47:0]           prod_q;
	logic [19:0]           quo_q;
	logic signed [19:0]    hum_q;

	logic [27:0]           p_bat;
	logic [35:0]           p_light;
	logic [32:0]           p_ir;
	logic [29:0]           p_h;
	logic signed [31:0]    a_nx;
	logic signed [16:0]    d1;
	logic [16:0]           e1;
	logic signed [34:0]    m2_nx;
	logic signed [16:0]    temp_nx;
	logic signed [47:0]    q1_nx;
	logic signed [47:0]    m2w;
	logic signed [47:0]    m8k_nx;
	logic signed [47:0]    sum_nx;
	logic [43:0]           p_est;
	logic [47:0]           prod_nx;
	logic                  div_ge;
	logic [47:0]           r_sub;
	logic signed [20:0]    hum_wide;
	logic                  out_take;

	assign pop = (state_q == ST_IDLE) && !q_empty;

	assign p_bat   = fr_q.battery * 12'd3000;
	assign p_light = fr_q.light * 20'd937500;
	assign p_ir    = fr_q.infrared * 17'd115350;
	assign p_h     = fr_q.humidity * 14'd15955;
	assign a_nx    = 32'sd367000000 - $signed({2'b00, p_h});
	assign d1      = $signed({1'b0, fr_q.temp}) - 17'sd6460;
	assign temp_nx = $signed({1'b0, fr_q.temp}) - 17'sd3960;
	assign e1      = {1'b0, fr_q.humidity} + 17'd125;
	assign m2_nx   = d1 * $signed({1'b0, e1});
	assign q1_nx   = $signed({1'b0, fr_q.humidity}) * a_q;
	assign m2w     = {{13{m2_q[34]}}, m2_q};
	// Times 8000 as 8192 - 128 - 64.
	assign m8k_nx  = (m2w <<< 13) - (m2w <<< 7) - (m2w <<< 6);
	assign sum_nx  = acc_q + m8k_q + HUM_BIAS;

	// The top 21 bits of the dividend times 2^50/1e8 never overshoot the quotient
	// and fall short of it by at most one.
	assign p_est    = r_q[46:26] * RECIP;
	assign prod_nx  = quo_q * DIVISOR;
	assign r_sub    = r_q - prod_q;
	assign div_ge   = (r_sub >= 48'(DIVISOR));
	assign hum_wide = $signed({1'b0, quo_q}) - HUM_SHIFT;
	assign out_take = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			fr_q              <= '0;
			bat_q             <= '0;
			light_q           <= '0;
			ir_q              <= '0;
			temp_q            <= '0;
			a_q               <= '0;
			m2_q              <= '0;
			acc_q             <= '0;
			m8k_q             <= '0;
			r_q               <= '0;
			prod_q            <= '0;
			quo_q             <= '0;
			hum_q             <= '0;
			out_valid         <= 1'b0;
			node_id           <= '0;
			battery_mv        <= '0;
			temp_centideg     <= '0;
			humidity_centipct <= '0;
			light_centilux    <= '0;
			infrared_centilux <= '0;
		end else begin
			if (out_take && (state_q != ST_OUT)) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						fr_q    <= q_data;
						state_q <= ST_BAT;
					end
				end
				ST_BAT: begin
					bat_q   <= p_bat[27:12];
					state_q <= ST_LIGHT;
				end
				ST_LIGHT: begin
					light_q <= p_light[35:12];
					state_q <= ST_IR;
				end
				ST_IR: begin
					ir_q    <= p_ir[32:12];
					state_q <= ST_A;
				end
				ST_A: begin
					a_q     <= a_nx;
					state_q <= ST_M2;
				end
				ST_M2: begin
					m2_q    <= m2_nx;
					temp_q  <= temp_nx;
					state_q <= ST_Q1;
				end
				ST_Q1: begin
					acc_q   <= q1_nx;
					state_q <= ST_M8K;
				end
				ST_M8K: begin
					m8k_q   <= m8k_nx;
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					acc_q   <= sum_nx;
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (acc_q < 0) begin
						hum_q   <= HUM_MIN;
						state_q <= ST_OUT;
					end else if (acc_q >= HUM_TOP) begin
						hum_q   <= HUM_MAX;
						state_q <= ST_OUT;
					end else begin
						r_q     <= acc_q;
						state_q <= ST_EST;
					end
				end
				ST_EST: begin
					quo_q   <= p_est[43:24];
					state_q <= ST_PROD;
				end
				ST_PROD: begin
					prod_q  <= prod_nx;
					state_q <= ST_FIX;
				end
				ST_FIX: begin
					if (div_ge) begin
						quo_q <= quo_q + 20'd1;
					end
					state_q <= ST_HUM;
				end
				ST_HUM: begin
					hum_q   <= hum_wide[19:0];
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid || !out_stall) begin
						out_valid         <= 1'b1;
						node_id           <= fr_q.node;
						battery_mv        <= bat_q;
						temp_centideg     <= temp_q;
						humidity_centipct <= hum_q;
						light_centilux    <= light_q;
						infrared_centilux <= ir_q;
						state_q           <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	// The estimate is never above the quotient and at most one below it.
	a_est_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIX) |-> ((r_q >= prod_q) && (r_sub < (48'(DIVISOR) << 1))))
		else $error("humidity quotient estimate out of range");
`endif

endmodule

// ===== src/sensor_frame_parse_convert.sv =====
// Top level of the sensor frame parser and converter: parser, frame queue and converter.
// Depends on sfpc_pkg, sfpc_front, sfpc_queue and sfpc_back.
//
//   channel  | handshake           | payload
//   ---------+---------------------+---------------------------------------------------
//   input    | in_valid, in_stall  | byte_in
//   output   | out_valid, out_stall| node_id, battery_mv, temp_centideg,
//            |                     | humidity_centipct, light_centilux, infrared_centilux
//
// The parser takes one byte per cycle and raises in_stall only while the frame queue is full.
// Each frame passes from queue to output register through a chain of one-multiply steps,
// ending in the humidity divide; the divide steps are skipped when humidity saturates.
// A result waits in the output register while out_stall is high; the converter holds once
// another result is ready, and the parser keeps taking bytes until the queue fills.
// Reset (arst_n low) returns the parser to hunting and empties the queue and output.
module sensor_frame_parse_convert #(
	parameter int QUEUE_DEPTH = sfpc_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         byte_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        node_id,
	output logic [15:0]        battery_mv,
	output logic signed [16:0] temp_centideg,
	output logic signed [19:0] humidity_centipct,
	output logic [23:0]        light_centilux,
	output logic [20:0]        infrared_centilux
);

	sfpc_pkg::frame_t push_data;
	sfpc_pkg::frame_t pop_data;
	logic             push;
	logic             pop;
	logic             q_full;
	logic             q_empty;

	sfpc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.byte_in   (byte_in),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	sfpc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (q_empty)
	);

	sfpc_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_empty           (q_empty),
		.q_data            (pop_data),
		.pop               (pop),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.node_id           (node_id),
		.battery_mv        (battery_mv),
		.temp_centideg     (temp_centideg),
		.humidity_centipct (humidity_centipct),
		.light_centilux    (light_centilux),
		.infrared_centilux (infrared_centilux)
	);

endmodule
